// File: rtl/core/gwrp_pkg.sv
// Package for the grouped weighted random pick block.
// Holds the request and result beat types, status and request codes.
// No dependencies.
`default_nettype none

package gwrp_pkg;

  localparam int WT_W  = 8;
  localparam int RND_W = 15;
  localparam int DCNT_W = $clog2(RND_W);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_PICK = 1'b1;

  localparam logic [2:0] ST_PICKED  = 3'd0;
  localparam logic [2:0] ST_NONE    = 3'd1;
  localparam logic [2:0] ST_ADDED   = 3'd2;
  localparam logic [2:0] ST_SKIPPED = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic             req_type;
    logic [7:0]       group_code;
    logic [WT_W-1:0]  entry_weight;
    logic [RND_W-1:0] random_value;
  } gwrp_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [3:0]      entry_number;
    logic [WT_W-1:0] picked_weight;
  } gwrp_out_t;

endpackage

`default_nettype wire

// File: rtl/core/gwrp_mem.sv
// Member memory: one write port, one read port with registered read data.
// Depends on nothing.
`default_nettype none

module gwrp_mem #(
  parameter int AW = 6,
  parameter int DW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gwrp_div.sv
// Restoring remainder unit, one dividend bit per cycle.
// Depends on gwrp_pkg for the dividend width.
`default_nettype none

module gwrp_div #(
  parameter int TW = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [gwrp_pkg::RND_W-1:0] dividend,
  input  wire logic [TW-1:0]             divisor,
  output logic                           done,
  output logic      [TW-1:0]             rem
);
  import gwrp_pkg::*;

  logic              run;
  logic [DCNT_W-1:0] cnt;
  logic [RND_W-1:0]  dvd;
  logic [TW-1:0]     dsr;
  logic [TW:0]       trial;

  assign trial = {rem, dvd[RND_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DCNT_W'(RND_W - 1);
        dvd <= dividend;
        dsr <= divisor;
        rem <= '0;
      end else if (run) begin
        dvd <= {dvd[RND_W-2:0], 1'b0};
        if (trial >= {1'b0, dsr}) begin
          rem <= TW'(trial - {1'b0, dsr});
        end else begin
          rem <= TW'(trial);
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/grouped_weighted_random_pick.sv
// Top level of the grouped weighted random pick block.
// Uses gwrp_pkg, gwrp_mem (member lists) and gwrp_div (remainder unit).
//
//   Channel   Ports                        Handshake
//   request   start, busy, req             beat taken when start & !busy
//   result    done, result                 beat taken at the edge ending done
//
// An add beat gives its result in the cycle after it is taken and leaves busy low.
// A pick on a non-empty valid group runs the remainder unit, then walks the
// group's entries with one member memory read per entry walked until one is
// picked or the list ends. Other picks answer in the cycle after they are taken.
// Synchronous reset clears counts, totals and the entry counter; the member
// memory is not cleared, and the block takes requests right after reset.
// The result port cannot be stalled.
`default_nettype none

module grouped_weighted_random_pick #(
  parameter int MAX_ENTRIES = 16,
  parameter int GROUP_COUNT = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire gwrp_pkg::gwrp_in_t  req,
  output logic                     done,
  output gwrp_pkg::gwrp_out_t      result
);
  import gwrp_pkg::*;

  localparam int EW    = $clog2(MAX_ENTRIES);
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int TW    = $clog2(MAX_ENTRIES * ((1 << WT_W) - 1) + 1);
  localparam int GW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int AW    = $clog2(GROUP_COUNT * MAX_ENTRIES);
  localparam int DW    = EW + WT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] loaded;
  logic [CW-1:0] counts [GROUP_COUNT];
  logic [TW-1:0] totals [GROUP_COUNT];

  logic [GW-1:0] grp_r;
  logic [CW-1:0] n_r;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] chk_idx;
  logic          have_data;
  logic [TW-1:0] r_w;

  logic            acc;
  logic [GW-1:0]   g;
  logic            grp_ok;
  logic [CW-1:0]   cnt_g;
  logic [TW-1:0]   tot_g;
  logic [WT_W-1:0] wt_eff;
  logic            full;
  logic            we;
  logic [AW-1:0]   waddr;
  logic            re;
  logic [AW-1:0]   raddr;
  logic [DW-1:0]   rdata;
  logic [WT_W-1:0] rd_wt;
  logic [EW-1:0]   rd_num;
  logic            div_start;
  logic            div_done;
  logic [TW-1:0]   div_rem;
  logic            issue;

  assign busy   = (state != S_IDLE);
  assign acc    = start && !busy;
  assign g      = GW'(req.group_code);
  assign grp_ok = (req.group_code < 8'(GROUP_COUNT));
  assign cnt_g  = counts[g];
  assign tot_g  = totals[g];
  assign wt_eff = (req.entry_weight == '0) ? WT_W'(1) : req.entry_weight;
  assign full   = (loaded >= CW'(MAX_ENTRIES));

  assign we    = acc && (req.req_type == REQ_ADD) && !full && grp_ok &&
                 (cnt_g < CW'(MAX_ENTRIES));
  assign waddr = AW'(AW'(g) * AW'(MAX_ENTRIES) + AW'(cnt_g));

  assign issue = (rd_idx < n_r);
  assign re    = (state == S_WALK) && issue;
  assign raddr = AW'(AW'(grp_r) * AW'(MAX_ENTRIES) + AW'(rd_idx));

  assign rd_wt  = rdata[WT_W-1:0];
  assign rd_num = rdata[DW-1:WT_W];

  assign div_start = acc && (req.req_type == REQ_PICK) && grp_ok &&
                     (cnt_g != '0) && (tot_g != '0);

  gwrp_mem #(
    .AW(AW),
    .DW(DW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({EW'(loaded), wt_eff}),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  gwrp_div #(
    .TW(TW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(req.random_value),
    .divisor (tot_g),
    .done    (div_done),
    .rem     (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      loaded    <= '0;
      have_data <= 1'b0;
      for (int i = 0; i < GROUP_COUNT; i++) begin
        counts[i] <= '0;
        totals[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            done <= 1'b1;
            result.entry_number  <= '0;
            result.picked_weight <= '0;
            if (req.req_type == REQ_ADD) begin
              if (full) begin
                result.status <= ST_FULL;
              end else begin
                loaded <= loaded + 1'b1;
                if (!grp_ok) begin
                  result.status       <= ST_SKIPPED;
                  result.entry_number <= 4'(loaded);
                end else if (cnt_g >= CW'(MAX_ENTRIES)) begin
                  result.status <= ST_FULL;
                end else begin
                  counts[g]            <= cnt_g + 1'b1;
                  totals[g]            <= tot_g + TW'(wt_eff);
                  result.status        <= ST_ADDED;
                  result.entry_number  <= 4'(loaded);
                  result.picked_weight <= wt_eff;
                end
              end
            end else if (div_start) begin
              done  <= 1'b0;
              state <= S_DIV;
              grp_r <= g;
              n_r   <= cnt_g;
            end else begin
              result.status <= ST_NONE;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state     <= S_WALK;
            r_w       <= div_rem;
            rd_idx    <= '0;
            have_data <= 1'b0;
          end
        end
        S_WALK: begin
          if (issue) begin
            rd_idx    <= rd_idx + 1'b1;
            chk_idx   <= rd_idx;
            have_data <= 1'b1;
          end else begin
            have_data <= 1'b0;
          end
          if (have_data) begin
            if (TW'(rd_wt) > r_w) begin
              done                 <= 1'b1;
              result.status        <= ST_PICKED;
              result.entry_number  <= 4'(rd_num);
              result.picked_weight <= rd_wt;
              state                <= S_IDLE;
              have_data            <= 1'b0;
            end else begin
              r_w <= r_w - TW'(rd_wt);
              if (chk_idx == n_r - 1'b1) begin
                done                 <= 1'b1;
                result.status        <= ST_NONE;
                result.entry_number  <= '0;
                result.picked_weight <= '0;
                state                <= S_IDLE;
                have_data            <= 1'b0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/gwrp_chk.sv
// Port-level checker for grouped_weighted_random_pick, bound to the top level.
// Depends on gwrp_pkg for the beat types and status codes.
`default_nettype none

module gwrp_chk (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire gwrp_pkg::gwrp_in_t  req,
  input wire logic                done,
  input wire gwrp_pkg::gwrp_out_t result
);
  import gwrp_pkg::*;

  a_add_answers_next: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (req.req_type == REQ_ADD) |=>
      done && (result.status != ST_PICKED) && (result.status != ST_NONE))
    else $error("add beat did not answer in the next cycle");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_FULL))
    else $error("result status out of range");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    done && ((result.status == ST_NONE) || (result.status == ST_FULL)) |->
      (result.entry_number == 4'd0) && (result.picked_weight == '0))
    else $error("no-candidate or full result carries data");

  a_weight_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && ((result.status == ST_PICKED) || (result.status == ST_ADDED)) |->
      (result.picked_weight != '0))
    else $error("picked or added entry shows zero weight");

  a_no_done_while_busy_start: assert property (@(posedge clk) disable iff (rst)
    busy && done |=> !busy)
    else $error("result beat while busy not followed by idle");

endmodule

bind grouped_weighted_random_pick gwrp_chk u_gwrp_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .result(result)
);

`default_nettype wire
